// File: src/iate_pkg.sv
// ----------------------------------------------------------------------------
// iate_pkg
// Shared field widths, request kind codes, status codes and defaults for the
// indexed array table engine.
// ----------------------------------------------------------------------------
package iate_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PREPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

endpackage

// File: src/iate_if.sv
// ----------------------------------------------------------------------------
// iate_if
// Valid/ready channels: request (kind, position, value) and response
// (status, result_index, read_value, fill_count).
// ----------------------------------------------------------------------------
interface iate_req_if;

    logic                         valid;
    logic                         ready;
    logic [iate_pkg::KIND_W-1:0]  kind;
    logic [iate_pkg::POS_W-1:0]   position;
    logic [iate_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);

endinterface

interface iate_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [iate_pkg::STATUS_W-1:0] status;
    logic [iate_pkg::INDEX_W-1:0]  result_index;
    logic [iate_pkg::VALUE_W-1:0]  read_value;
    logic [iate_pkg::COUNT_W-1:0]  fill_count;

    modport source (output valid, output status, output result_index, output read_value,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input result_index, input read_value,
                    input fill_count, output ready);

endinterface

// File: src/iate_mem.sv
// ----------------------------------------------------------------------------
// iate_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iate_mem #(
    parameter int  CAPACITY    = iate_pkg::DEF_CAPACITY,
    parameter int  ENTRY_WIDTH = iate_pkg::DEF_ENTRY_WIDTH,
    parameter type cmd_t       = logic
) (
    input  logic                   clk,
    input  cmd_t                   cmd,
    output logic [ENTRY_WIDTH-1:0] rd_data
);

    logic [ENTRY_WIDTH-1:0] entries_mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entries_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entries_mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/iate_ctrl.sv
// ----------------------------------------------------------------------------
// iate_ctrl
// Request sequencer: decodes a request, drives the entry store through
// shift, search and single-entry passes, and holds the response register.
// ----------------------------------------------------------------------------
module iate_ctrl #(
    parameter int  CAPACITY    = iate_pkg::DEF_CAPACITY,
    parameter int  ENTRY_WIDTH = iate_pkg::DEF_ENTRY_WIDTH,
    parameter type cmd_t       = logic
) (
    input  logic                   clk,
    input  logic                   rst_n,
    iate_req_if.sink               req,
    iate_rsp_if.source             rsp,
    output cmd_t                   mem_cmd,
    input  logic [ENTRY_WIDTH-1:0] rd_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > iate_pkg::POS_W) ? CW : iate_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_PRE_WR,
        S_FIND,
        S_GET,
        S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [iate_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [iate_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ENTRY_WIDTH-1:0]         val_reg, val_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  src_reg, src_next;
    logic [CW-1:0]                  rd_left_reg, rd_left_next;
    logic                           wb_valid_reg, wb_valid_next;
    logic [AW-1:0]                  wb_addr_reg, wb_addr_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                  cmp_idx_reg, cmp_idx_next;
    iate_pkg::status_t              st_status_reg, st_status_next;
    logic [iate_pkg::INDEX_W-1:0]   st_index_reg, st_index_next;
    logic [iate_pkg::VALUE_W-1:0]   st_rdata_reg, st_rdata_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [iate_pkg::STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [iate_pkg::INDEX_W-1:0]   rsp_index_reg, rsp_index_next;
    logic [iate_pkg::VALUE_W-1:0]   rsp_rdata_reg, rsp_rdata_next;
    logic [iate_pkg::COUNT_W-1:0]   rsp_count_reg, rsp_count_next;

    logic                           fin;
    iate_pkg::status_t              fin_status;
    logic [iate_pkg::INDEX_W-1:0]   fin_index;
    logic [iate_pkg::VALUE_W-1:0]   fin_rdata;
    logic [CW-1:0]                  fin_count;

    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic                           in_range;
    logic                           full;
    logic                           issue;
    logic                           is_prepend;

    assign pos_ext    = PW'(pos_reg);
    assign cnt_ext    = PW'(count_reg);
    assign in_range   = pos_ext < cnt_ext;
    assign full       = count_reg == CW'(CAPACITY);
    assign issue      = rd_left_reg != '0;
    assign is_prepend = kind_reg == iate_pkg::KIND_PREPEND;

    assign req.ready        = state_reg == S_IDLE;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_index = rsp_index_reg;
    assign rsp.read_value   = rsp_rdata_reg;
    assign rsp.fill_count   = rsp_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        rd_left_next    = rd_left_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = wb_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        st_status_next  = st_status_reg;
        st_index_next   = st_index_reg;
        st_rdata_next   = st_rdata_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_rdata_next  = rsp_rdata_reg;
        rsp_count_next  = rsp_count_reg;

        fin        = 1'b0;
        fin_status = iate_pkg::ST_OK;
        fin_index  = '0;
        fin_rdata  = '0;
        fin_count  = count_reg;

        mem_cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    pos_next   = req.position;
                    val_next   = ENTRY_WIDTH'(req.value);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (kind_reg)
                    iate_pkg::KIND_APPEND:
                    begin
                        fin = 1'b1;
                        if (full)
                        begin
                            fin_status = iate_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = AW'(count_reg);
                            mem_cmd.wr_data = val_reg;
                            fin_index       = iate_pkg::INDEX_W'(count_reg);
                            fin_count       = count_reg + CW'(1);
                        end
                    end
                    iate_pkg::KIND_PREPEND:
                    begin
                        if (full)
                        begin
                            fin        = 1'b1;
                            fin_status = iate_pkg::ST_FULL;
                        end
                        else
                        begin
                            // shift runs from the top entry down to slot 0
                            src_next     = AW'(count_reg - CW'(1));
                            rd_left_next = count_reg;
                            state_next   = S_SHIFT;
                        end
                    end
                    iate_pkg::KIND_REMOVE:
                    begin
                        if (!in_range)
                        begin
                            fin        = 1'b1;
                            fin_status = iate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            src_next     = AW'(pos_ext + PW'(1));
                            rd_left_next = CW'(cnt_ext - pos_ext - PW'(1));
                            state_next   = S_SHIFT;
                        end
                    end
                    iate_pkg::KIND_FIND:
                    begin
                        src_next     = '0;
                        rd_left_next = count_reg;
                        state_next   = S_FIND;
                    end
                    iate_pkg::KIND_GET:
                    begin
                        if (!in_range)
                        begin
                            fin        = 1'b1;
                            fin_status = iate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = AW'(pos_ext);
                            state_next      = S_GET;
                        end
                    end
                    iate_pkg::KIND_SET:
                    begin
                        fin = 1'b1;
                        if (!in_range)
                        begin
                            fin_status = iate_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = AW'(pos_ext);
                            mem_cmd.wr_data = val_reg;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // read one entry per cycle, write it back one slot over in the next cycle
                if (issue)
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = src_reg;
                    src_next        = is_prepend ? src_reg - AW'(1) : src_reg + AW'(1);
                    wb_addr_next    = is_prepend ? src_reg + AW'(1) : src_reg - AW'(1);
                    rd_left_next    = rd_left_reg - CW'(1);
                    wb_valid_next   = 1'b1;
                end
                if (wb_valid_reg)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = wb_addr_reg;
                    mem_cmd.wr_data = rd_data;
                end
                if (!issue && !wb_valid_reg)
                begin
                    if (is_prepend)
                    begin
                        state_next = S_PRE_WR;
                    end
                    else
                    begin
                        fin       = 1'b1;
                        fin_count = count_reg - CW'(1);
                    end
                end
            end

            S_PRE_WR:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = '0;
                mem_cmd.wr_data = val_reg;
                fin             = 1'b1;
                fin_count       = count_reg + CW'(1);
            end

            S_FIND:
            begin
                if (issue)
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = src_reg;
                    src_next        = src_reg + AW'(1);
                    rd_left_next    = rd_left_reg - CW'(1);
                    cmp_valid_next  = 1'b1;
                    cmp_idx_next    = src_reg;
                end
                // most cycles of a search neither hit nor finish
                if (cmp_valid_reg && rd_data == val_reg)
                begin
                    fin       = 1'b1;
                    fin_index = iate_pkg::INDEX_W'(cmp_idx_reg);
                end
                else if (!issue && !cmp_valid_reg)
                begin
                    fin        = 1'b1;
                    fin_status = iate_pkg::ST_MISS;
                end
            end

            S_GET:
            begin
                fin       = 1'b1;
                fin_rdata = iate_pkg::VALUE_W'(rd_data);
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = st_status_reg;
                    rsp_index_next  = st_index_reg;
                    rsp_rdata_next  = st_rdata_reg;
                    rsp_count_next  = iate_pkg::COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            st_status_next = fin_status;
            st_index_next  = fin_index;
            st_rdata_next  = fin_rdata;
            count_next     = fin_count;
            state_next     = S_RESP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            wb_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            wb_valid_reg  <= wb_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        src_reg        <= src_next;
        wb_addr_reg    <= wb_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        st_status_reg  <= st_status_next;
        st_index_reg   <= st_index_next;
        st_rdata_reg   <= st_rdata_next;
        rsp_status_reg <= rsp_status_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_rdata_reg  <= rsp_rdata_next;
        rsp_count_reg  <= rsp_count_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CW'(1)) ||
                 (count_reg == $past(count_reg) - CW'(1)))
        else $error("fill count moved by more than one");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.wr_en && mem_cmd.rd_en) |-> (mem_cmd.wr_addr != mem_cmd.rd_addr))
        else $error("read and write hit the same entry");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !mem_cmd.wr_en)
        else $error("entry write while taking a request");
`endif

endmodule

// File: src/indexed_array_table_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_array_table_engine_unit
// Dense ordered table of entries with append, prepend, remove, find, get and
// set, one response per request.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with exactly one response; a
// new request is accepted while the previous response still waits in the
// output register. Entries live in a single-port-write, single-port-read
// memory with a registered read, and every multi-entry pass moves one entry
// per cycle through that port pair. Append, set, unused kinds and every
// rejected request finish in the execute state; get adds one registered
// read; find reads entries upward from index 0 until a hit or the end;
// prepend shifts every entry up one slot and then writes slot 0; remove
// shifts the entries above the position down one slot. A request waits to
// load its response while the previous response still holds the output
// register. No clearing pass follows reset: entries are undefined until
// written and only entries below the fill count are ever read.
module indexed_array_table_engine_unit #(
    parameter int CAPACITY    = iate_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = iate_pkg::DEF_ENTRY_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    iate_req_if.sink   req,
    iate_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef struct packed {
        logic                   wr_en;
        logic [AW-1:0]          wr_addr;
        logic [ENTRY_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [AW-1:0]          rd_addr;
    } mem_cmd_t;

    mem_cmd_t               mem_cmd;
    logic [ENTRY_WIDTH-1:0] rd_data;

    iate_ctrl #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .cmd_t       (mem_cmd_t)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .rd_data (rd_data)
    );

    iate_mem #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .cmd_t       (mem_cmd_t)
    ) u_mem (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

endmodule
